/* rtl/itab_pkg.sv */
// Shared types and constants for the innovation table engine.
`timescale 1ns / 1ps

package itab_pkg;

  // Table geometry and identifier width
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned IdW        = 16;

  // Operation codes carried in the action field
  typedef enum logic [2:0] {
    ActFind          = 3'd0,
    ActAddLink       = 3'd1,
    ActAddNeuron     = 3'd2,
    ActFetchNeuron   = 3'd3,
    ActNeuronOfInnov = 3'd4
  } action_e;

  // Entry kinds
  localparam logic KindNeuron = 1'b0;
  localparam logic KindLink   = 1'b1;

  // Configuration register indexes (paddr bit 2)
  localparam logic RegFirstInnov  = 1'b0;
  localparam logic RegFirstNeuron = 1'b1;

  // Control sequencer, one-hot
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  typedef struct packed {
    logic [2:0]     action;
    logic [15:0]    source_neuron;
    logic [15:0]    target_neuron;
    logic           entry_kind;
    logic [2:0]     node_type_in;
    logic [15:0]    split_x_in;
    logic [15:0]    split_y_in;
    logic [15:0]    query_neuron;
    logic [15:0]    query_innovation;
  } itab_in_t;

  typedef struct packed {
    logic           found;
    logic           table_full;
    logic [15:0]    innovation_out;
    logic [15:0]    neuron_out;
    logic [2:0]     node_type_out;
    logic [15:0]    split_x_out;
    logic [15:0]    split_y_out;
  } itab_out_t;

  // One stored table entry
  typedef struct packed {
    logic           kind;
    logic [IdW-1:0] source;
    logic [IdW-1:0] target;
    logic [IdW-1:0] innovation;
    logic [IdW-1:0] neuron;
    logic [2:0]     node_type;
    logic [15:0]    split_x;
    logic [15:0]    split_y;
  } itab_entry_t;

endpackage

/* rtl/itab_store.sv */
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps

module itab_store (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [itab_pkg::IdxW-1:0]   wr_addr_i,
  input  itab_pkg::itab_entry_t       wr_data_i,
  input  logic                        rd_en_i,
  input  logic [itab_pkg::IdxW-1:0]   rd_addr_i,
  output itab_pkg::itab_entry_t       rd_data_o
);
  import itab_pkg::*;

  itab_entry_t mem [TableDepth];
  itab_entry_t rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/innovation_table_engine.sv */
// Top level of the innovation table engine: sequencer, counters, config port.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on in_valid_i/in_data_i and are taken at an edge with
//   in_valid_i high and in_stall_o low. Each request gives exactly one
//   result on out_valid_o/out_data_o, held until out_stall_i is low.
//   Appends (add link, add neuron) and unknown actions answer in the cycle
//   after the transfer. Searches scan the entries one per cycle in insertion
//   order through the single read port of the entry memory; a search ends
//   at the first hit or after the last stored entry, and its result passes
//   through the result register into the output register. A full table
//   holds 1024 entries.
//   One request is worked on at a time; a new search may be taken while a
//   result still waits in the output register, an append only once that
//   register is free or being emptied.
//   A stalled output holds its result and finally blocks new requests.
//   Reset empties the table (fill count zero, no clearing pass) and sets
//   both start registers and counters to zero. APB writes to the start
//   registers (byte 0: first innovation, byte 4: first neuron) also load
//   the matching counter; write them only while the block is idle.

module innovation_table_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itab_pkg::itab_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itab_pkg::itab_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import itab_pkg::*;

  state_e              state_q, state_d;
  itab_in_t            req_q;
  logic [CntW-1:0]     used_q;
  logic [CntW-1:0]     issue_q;
  logic                pend_q;
  itab_out_t           res_q;
  itab_out_t           out_q;
  logic                out_valid_q;
  logic [IdW-1:0]      innov_cnt_q;
  logic [IdW-1:0]      neuron_cnt_q;
  logic [15:0]         first_innov_q;
  logic [15:0]         first_neuron_q;

  logic                accept_in;
  logic                is_scan;
  logic                is_append;
  logic                out_free;
  logic                tbl_full;
  logic                wr_en;
  itab_entry_t         wr_entry;
  logic                rd_en;
  itab_entry_t         rd_entry;
  logic                hit;
  itab_out_t           hit_res;
  itab_out_t           imm_res;
  logic                load_done;
  logic                cfg_wr;

  // Request decode
  assign is_scan   = (in_data_i.action == ActFind) ||
                     (in_data_i.action == ActFetchNeuron) ||
                     (in_data_i.action == ActNeuronOfInnov);
  assign is_append = (in_data_i.action == ActAddLink) ||
                     (in_data_i.action == ActAddNeuron);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign tbl_full  = (used_q == CntW'(TableDepth));

  assign in_stall_o = (state_q != StIdle) || (!is_scan && !out_free);
  assign accept_in  = in_valid_i && !in_stall_o;

  // Append path: new entry and immediate answer
  always_comb begin
    wr_entry            = '0;
    wr_entry.source     = in_data_i.source_neuron;
    wr_entry.target     = in_data_i.target_neuron;
    wr_entry.innovation = innov_cnt_q;
    imm_res             = '0;
    if (in_data_i.action == ActAddNeuron) begin
      wr_entry.kind      = KindNeuron;
      wr_entry.neuron    = neuron_cnt_q;
      wr_entry.node_type = in_data_i.node_type_in;
      wr_entry.split_x   = in_data_i.split_x_in;
      wr_entry.split_y   = in_data_i.split_y_in;
    end else begin
      wr_entry.kind      = KindLink;
    end
    if (is_append) begin
      if (tbl_full) begin
        imm_res.table_full = 1'b1;
      end else begin
        imm_res.found          = 1'b1;
        imm_res.innovation_out = innov_cnt_q;
        if (in_data_i.action == ActAddNeuron) begin
          imm_res.neuron_out = neuron_cnt_q;
        end
      end
    end
  end

  assign wr_en = accept_in && is_append && !tbl_full;

  // Entry memory
  assign rd_en = (state_q == StScan) && (issue_q != used_q);

  itab_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (used_q[IdxW-1:0]),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[IdxW-1:0]),
    .rd_data_o (rd_entry)
  );

  // Match test on the entry read in the previous cycle
  always_comb begin
    hit     = 1'b0;
    hit_res = '0;
    case (action_e'(req_q.action))
      ActFind: begin
        hit = (rd_entry.source == req_q.source_neuron) &&
              (rd_entry.target == req_q.target_neuron) &&
              (rd_entry.kind == req_q.entry_kind);
        hit_res.found          = 1'b1;
        hit_res.innovation_out = rd_entry.innovation;
      end
      ActFetchNeuron: begin
        hit = (rd_entry.kind == KindNeuron) && (rd_entry.neuron == req_q.query_neuron);
        hit_res.found          = 1'b1;
        hit_res.innovation_out = rd_entry.innovation;
        hit_res.neuron_out     = rd_entry.neuron;
        hit_res.node_type_out  = rd_entry.node_type;
        hit_res.split_x_out    = rd_entry.split_x;
        hit_res.split_y_out    = rd_entry.split_y;
      end
      ActNeuronOfInnov: begin
        // first entry with this number decides; a link entry answers a miss
        hit = (rd_entry.innovation == req_q.query_innovation);
        if (rd_entry.kind == KindNeuron) begin
          hit_res.found          = 1'b1;
          hit_res.innovation_out = rd_entry.innovation;
          hit_res.neuron_out     = rd_entry.neuron;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept_in && is_scan) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if ((pend_q && hit) || (!pend_q && (issue_q == used_q))) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign load_done = (state_q == StDone) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      issue_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_in && is_scan) begin
        issue_q <= '0;
        pend_q  <= 1'b0;
      end else if (state_q == StScan) begin
        pend_q <= rd_en;
        if (rd_en) begin
          issue_q <= issue_q + CntW'(1);
        end
      end
    end
  end

  // Request and scan result holding
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      req_q <= in_data_i;
    end
    if (state_q == StScan) begin
      if (pend_q && hit) begin
        res_q <= hit_res;
      end else begin
        res_q <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((accept_in && !is_scan) || load_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in && !is_scan) begin
      out_q <= imm_res;
    end else if (load_done) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Fill count, counters and configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q         <= '0;
      innov_cnt_q    <= '0;
      neuron_cnt_q   <= '0;
      first_innov_q  <= '0;
      first_neuron_q <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == RegFirstInnov) begin
          first_innov_q <= pwdata[15:0];
          innov_cnt_q   <= pwdata[IdW-1:0];
        end else begin
          first_neuron_q <= pwdata[15:0];
          neuron_cnt_q   <= pwdata[IdW-1:0];
        end
      end else if (wr_en) begin
        used_q      <= used_q + CntW'(1);
        innov_cnt_q <= innov_cnt_q + IdW'(1);
        if (in_data_i.action == ActAddNeuron) begin
          neuron_cnt_q <= neuron_cnt_q + IdW'(1);
        end
      end
    end
  end

  // Register read
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegFirstInnov) begin
      prdata[15:0] = first_innov_q;
    end else begin
      prdata[15:0] = first_neuron_q;
    end
  end

endmodule
